// File: hdl/stcu_pkg.sv
// ----------------------------------------------------------------------------
// stcu_pkg: shared types and constants of the two-point calibration unit
// Register codes, calibration word, pipeline sideband and divider word.
// ----------------------------------------------------------------------------
package stcu_pkg;

  // Input, register and result widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int VALUE_W  = 32;

  // Datapath widths: raw difference, scaled span, base, product, quotient
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int SPAN_W = 16;
  localparam int BASE_W = 15;
  localparam int PROD_W = DIFF_W + SPAN_W;
  localparam int QUO_W  = 32;
  localparam int DEN_W  = 16;

  // Scale shifts: temperature x32, humidity x128
  localparam int TEMP_SHIFT = 5;
  localparam int HUM_SHIFT  = 7;

  // Configuration register codes
  typedef enum logic [IDX_W-1:0] {
    REG_TEMP_LOW_POINT  = 3'd0,
    REG_TEMP_HIGH_POINT = 3'd1,
    REG_TEMP_LOW_RAW    = 3'd2,
    REG_TEMP_HIGH_RAW   = 3'd3,
    REG_HUM_LOW_POINT   = 3'd4,
    REG_HUM_HIGH_POINT  = 3'd5,
    REG_HUM_LOW_RAW     = 3'd6,
    REG_HUM_HIGH_RAW    = 3'd7
  } stcu_reg_t;

  // Channel select codes
  localparam logic FUNC_TEMP = 1'b0;
  localparam logic FUNC_HUM  = 1'b1;

  // Full set of calibration registers
  typedef struct packed {
    logic [9:0]  temp_low_point_x8;
    logic [9:0]  temp_high_point_x8;
    logic [15:0] temp_low_raw;
    logic [15:0] temp_high_raw;
    logic [7:0]  hum_low_point_x2;
    logic [7:0]  hum_high_point_x2;
    logic [15:0] hum_low_raw;
    logic [15:0] hum_high_raw;
  } stcu_cal_t;

  // Sideband that travels with a word through the divider
  typedef struct packed {
    logic              neg;
    logic              err;
    logic [BASE_W-1:0] base;
  } stcu_side_t;

  // One word in the divider pipeline
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] acc;
    logic [DEN_W-1:0] den;
    stcu_side_t       side;
  } stcu_div_t;

endpackage

// File: hdl/sensor_two_point_calibration_unit.sv
// ----------------------------------------------------------------------------
// sensor_two_point_calibration_unit: two-point linear sensor calibration
// Converts raw temperature or humidity words to 1/256 units.
// ----------------------------------------------------------------------------
// A new word is taken in every cycle while in_stall is low. The pipeline has
// three front-end stages (channel select and differences, 17x16 multiply,
// sign and magnitude), 32 stages of a one-bit-per-stage divider and one
// output register. The whole pipeline moves as one; in_stall is high exactly
// while a finished result waits at the output under out_stall, so throughput
// is one word a cycle whenever the sink takes results. Calibration registers
// are written through cfg_we, cfg_index and cfg_data and take effect on
// words accepted after the write; equal raw points give div_error and 0.
// ----------------------------------------------------------------------------
module sensor_two_point_calibration_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stcu_pkg::IDX_W-1:0]    cfg_index,
  input  logic [stcu_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [stcu_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stcu_pkg::VALUE_W-1:0]  value,
  output logic                          div_error
);
  import stcu_pkg::*;

  stcu_cal_t cal;
  logic      en;
  logic      prep_valid;
  stcu_div_t prep_word;
  logic      div_valid;
  stcu_div_t div_word;

  // Freeze the pipeline while a result waits at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  stcu_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  stcu_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cal       (cal),
    .in_valid  (in_valid),
    .func      (func),
    .sample    (sample),
    .out_valid (prep_valid),
    .out_word  (prep_word)
  );

  stcu_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .in_word   (prep_word),
    .out_valid (div_valid),
    .out_word  (div_word)
  );

  stcu_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_word   (div_word),
    .out_valid (out_valid),
    .value     (value),
    .div_error (div_error)
  );

  // A zero denominator always yields a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_error |-> value == '0)
    else $error("div_error result with non-zero value");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // A held input side means the output word is frozen
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> out_valid && $stable(value) && $stable(div_error))
    else $error("pipeline moved while stalled");

endmodule

// File: hdl/stcu_regs.sv
// ----------------------------------------------------------------------------
// stcu_regs: calibration register file
// Takes register writes and keeps the low bits of each register's width.
// ----------------------------------------------------------------------------
module stcu_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [stcu_pkg::IDX_W-1:0]  cfg_index,
  input  logic [stcu_pkg::CFG_W-1:0]  cfg_data,
  output stcu_pkg::stcu_cal_t         cal
);
  import stcu_pkg::*;

  stcu_cal_t regs;
  stcu_cal_t regs_next;

  // Decode the write into the register set
  always_comb begin
    regs_next = regs;
    if (cfg_we) begin
      case (stcu_reg_t'(cfg_index))
        REG_TEMP_LOW_POINT:  regs_next.temp_low_point_x8  = cfg_data[9:0];
        REG_TEMP_HIGH_POINT: regs_next.temp_high_point_x8 = cfg_data[9:0];
        REG_TEMP_LOW_RAW:    regs_next.temp_low_raw       = cfg_data;
        REG_TEMP_HIGH_RAW:   regs_next.temp_high_raw      = cfg_data;
        REG_HUM_LOW_POINT:   regs_next.hum_low_point_x2   = cfg_data[7:0];
        REG_HUM_HIGH_POINT:  regs_next.hum_high_point_x2  = cfg_data[7:0];
        REG_HUM_LOW_RAW:     regs_next.hum_low_raw        = cfg_data;
        REG_HUM_HIGH_RAW:    regs_next.hum_high_raw       = cfg_data;
        default:             regs_next = regs;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else begin
      regs <= regs_next;
    end
  end

  assign cal = regs;

endmodule

// File: hdl/stcu_prep.sv
// ----------------------------------------------------------------------------
// stcu_prep: front end of the calibration pipeline
// Three stages: channel select and differences, multiply, sign and magnitude.
// ----------------------------------------------------------------------------
module stcu_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  stcu_pkg::stcu_cal_t           cal,
  input  logic                          in_valid,
  input  logic                          func,
  input  logic [stcu_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  output stcu_pkg::stcu_div_t           out_word
);
  import stcu_pkg::*;

  // Stage 1 combinational
  logic [SAMPLE_W-1:0] o0;
  logic [SAMPLE_W-1:0] o1;
  logic [10:0]         temp_dx;
  logic [8:0]          hum_dx;
  logic [SPAN_W-1:0]   span_c;
  logic [BASE_W-1:0]   base_c;

  // Stage registers
  logic                     v1;
  logic                     v2;
  logic                     v3;
  logic signed [DIFF_W-1:0] s1_diff;
  logic signed [SPAN_W-1:0] s1_span;
  logic signed [DIFF_W-1:0] s1_den;
  logic [BASE_W-1:0]        s1_base;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [DIFF_W-1:0] s2_den;
  logic [BASE_W-1:0]        s2_base;
  stcu_div_t                s3_word;

  // Stage 3 combinational
  logic [PROD_W-1:0] prod_mag;
  logic [DIFF_W-1:0] den_mag;

  // Select the channel's calibration points and scale the span and base
  always_comb begin
    temp_dx = {1'b0, cal.temp_high_point_x8} - {1'b0, cal.temp_low_point_x8};
    hum_dx  = {1'b0, cal.hum_high_point_x2} - {1'b0, cal.hum_low_point_x2};
    if (func == FUNC_HUM) begin
      o0     = cal.hum_low_raw;
      o1     = cal.hum_high_raw;
      span_c = {hum_dx, {HUM_SHIFT{1'b0}}};
      base_c = {cal.hum_low_point_x2, {HUM_SHIFT{1'b0}}};
    end else begin
      o0     = cal.temp_low_raw;
      o1     = cal.temp_high_raw;
      span_c = {temp_dx, {TEMP_SHIFT{1'b0}}};
      base_c = {cal.temp_low_point_x8, {TEMP_SHIFT{1'b0}}};
    end
  end

  // Stage 1: differences of sample and raw points
  always_ff @(posedge clk) begin
    if (en) begin
      s1_diff <= $signed({sample[SAMPLE_W-1], sample}) - $signed({o0[SAMPLE_W-1], o0});
      s1_den  <= $signed({o1[SAMPLE_W-1], o1}) - $signed({o0[SAMPLE_W-1], o0});
      s1_span <= $signed(span_c);
      s1_base <= base_c;
    end
  end

  // Stage 2: numerator product
  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod <= PROD_W'(s1_diff) * PROD_W'(s1_span);
      s2_den  <= s1_den;
      s2_base <= s1_base;
    end
  end

  // Stage 3: split into sign and magnitudes for the divider
  always_comb begin
    prod_mag = s2_prod[PROD_W-1] ? PROD_W'(-s2_prod) : PROD_W'(s2_prod);
    den_mag  = s2_den[DIFF_W-1] ? DIFF_W'(-s2_den) : DIFF_W'(s2_den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_word.rem       <= '0;
      s3_word.acc       <= prod_mag[QUO_W-1:0];
      s3_word.den       <= den_mag[DEN_W-1:0];
      s3_word.side.neg  <= s2_prod[PROD_W-1] ^ s2_den[DIFF_W-1];
      s3_word.side.err  <= (s2_den == '0);
      s3_word.side.base <= s2_base;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign out_word  = s3_word;

endmodule

// File: hdl/stcu_div_step.sv
// ----------------------------------------------------------------------------
// stcu_div_step: one registered step of the restoring divider
// Shifts one dividend bit into the remainder and sets one quotient bit.
// ----------------------------------------------------------------------------
module stcu_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  stcu_pkg::stcu_div_t in_word,
  output logic                out_valid,
  output stcu_pkg::stcu_div_t out_word
);
  import stcu_pkg::*;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  stcu_div_t        word_next;
  logic             valid;
  stcu_div_t        word;

  // Try subtracting the divisor from the shifted remainder
  always_comb begin
    trial     = {in_word.rem, in_word.acc[QUO_W-1]};
    diff      = trial - {1'b0, in_word.den};
    fits      = (trial >= {1'b0, in_word.den});
    word_next = in_word;
    word_next.rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    word_next.acc = {in_word.acc[QUO_W-2:0], fits};
  end

  // Register the step
  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// File: hdl/stcu_divider.sv
// ----------------------------------------------------------------------------
// stcu_divider: pipelined unsigned divider
// One quotient bit per stage; the quotient replaces the dividend bits.
// ----------------------------------------------------------------------------
module stcu_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  stcu_pkg::stcu_div_t in_word,
  output logic                out_valid,
  output stcu_pkg::stcu_div_t out_word
);
  import stcu_pkg::*;

  logic      valid [QUO_W+1];
  stcu_div_t word  [QUO_W+1];

  assign valid[0] = in_valid;
  assign word[0]  = in_word;

  // Chain of divider steps
  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    stcu_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid[i]),
      .in_word   (word[i]),
      .out_valid (valid[i+1]),
      .out_word  (word[i+1])
    );
  end

  assign out_valid = valid[QUO_W];
  assign out_word  = word[QUO_W];

endmodule

// File: hdl/stcu_post.sv
// ----------------------------------------------------------------------------
// stcu_post: output stage
// Restores the sign, adds the base point, saturates and registers the word.
// ----------------------------------------------------------------------------
module stcu_post (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  stcu_pkg::stcu_div_t          in_word,
  output logic                         out_valid,
  output logic [stcu_pkg::VALUE_W-1:0] value,
  output logic                         div_error
);
  import stcu_pkg::*;

  localparam int SUM_W = QUO_W + 2;

  logic [QUO_W:0]     quo_s;
  logic [SUM_W-1:0]   sum;
  logic [VALUE_W-1:0] value_next;
  logic               valid;

  // Signed quotient plus base, clamped to 32 bits; zero on a divide error
  always_comb begin
    quo_s = in_word.side.neg ? (QUO_W+1)'(-{1'b0, in_word.acc}) : {1'b0, in_word.acc};
    sum   = {quo_s[QUO_W], quo_s} + SUM_W'(in_word.side.base);
    if (in_word.side.err) begin
      value_next = '0;
    end else if (sum[SUM_W-1:VALUE_W-1] == '0 || sum[SUM_W-1:VALUE_W-1] == '1) begin
      value_next = sum[VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      value_next = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      value_next = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      value     <= value_next;
      div_error <= in_word.side.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  assign out_valid = valid;

endmodule
